[rtl/tasi_pkg.sv]
// Shared types, constants and helpers of the three-axis step interpolator.
package tasi_pkg;

	localparam int POS_W      = 32;
	localparam int DIST_W     = POS_W + 1;
	localparam int REM_W      = POS_W + 2;
	localparam int COORD_W    = 32;
	localparam int IVAL_W     = 16;
	localparam int OP_W       = 2;
	localparam int NUM_AXES   = 3;
	localparam int IN_DATA_W  = ((3 * COORD_W + 3 + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((7 + 3 * COORD_W + 7) / 8) * 8;

	localparam logic [IVAL_W-1:0] IVAL_RESET = IVAL_W'(500);

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [REM_W-1:0]   rem_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_MOVE     = 2'd1,
		MODE_HOME_ALL = 2'd2,
		MODE_HOME_X   = 2'd3
	} mode_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 2'd0,
		OP_MOVE     = 2'd1,
		OP_HOME_ALL = 2'd2,
		OP_HOME_X   = 2'd3
	} op_t;

	// Move state right after the first step period of a new move
	typedef struct packed {
		logic [NUM_AXES-1:0]  dir;
		dist_t [NUM_AXES-1:0] span;
		axis_t                major;
		logic                 active;
		logic [NUM_AXES-1:0]  step;
		dist_t [NUM_AXES-1:0] cnt;
		rem_t [1:0]           rem;
	} tasi_plan_t;

	// Outcome of one step period of a running move
	typedef struct packed {
		logic                 done;
		logic [NUM_AXES-1:0]  step;
		dist_t [NUM_AXES-1:0] cnt;
		rem_t [1:0]           rem;
	} tasi_period_t;

	// Minor axes of a given major axis, in X, Y, Z order
	function automatic axis_t minor_axis(input axis_t major, input logic second);
		axis_t res;
		case (major)
			AXIS_X: res = second ? AXIS_Z : AXIS_Y;
			AXIS_Y: res = second ? AXIS_Z : AXIS_X;
			default: res = second ? AXIS_Y : AXIS_X;
		endcase
		return res;
	endfunction

endpackage

[rtl/three_axis_step_interpolator_unit.sv]
// Top level of the three-axis step interpolator: handshake, state and result register.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tuser: operation; tdata: targets, limits
//  m_axis    out        m_axis_tvalid/tready       tdata: steps, dirs, busy, positions
//  cfg       in         cfg_valid/cfg_ready        cfg_data: step_interval
//
// One item is one tick. An item passes the input register and then the result
// register; one item a cycle sustained while the output is not stalled, with
// the state update between the two registers.
// arst_n clears the axis state, idles the block and loads step_interval 500.
// A stalled output holds the result and the input register; the input side
// keeps taking items until the input register is full.
module three_axis_step_interpolator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] target_x, [63:32] target_y, [95:64] target_z,
	// [96] limit_x_open, [97] limit_y_open, [98] limit_z_open, rest zero
	input  logic [tasi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] operation
	input  logic [tasi_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] step_x, [1] step_y, [2] step_z, [3] dir_x, [4] dir_y, [5] dir_z,
	// [6] busy_res, [38:7] pos_x, [70:39] pos_y, [102:71] pos_z, rest zero
	output logic [tasi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tasi_pkg::IVAL_W-1:0]         cfg_data
);
	import tasi_pkg::*;

	// Input register
	logic                   valid_s1;
	op_t                    op_s1;
	coord_t [NUM_AXES-1:0]  tgt_s1;
	logic [NUM_AXES-1:0]    lim_s1;

	// Block state
	logic [IVAL_W-1:0]      ival_cfg_q;
	pos_t [NUM_AXES-1:0]    pos_q;
	logic [NUM_AXES-1:0]    dir_q;
	dist_t [NUM_AXES-1:0]   dist_q;
	dist_t [NUM_AXES-1:0]   cnt_q;
	rem_t [1:0]             rem_q;
	axis_t                  major_q;
	mode_t                  mode_q;
	logic [IVAL_W-1:0]      ival_q;

	// Result register
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	// Next values
	pos_t [NUM_AXES-1:0]    pos_n;
	logic [NUM_AXES-1:0]    dir_n;
	dist_t [NUM_AXES-1:0]   dist_n;
	dist_t [NUM_AXES-1:0]   cnt_n;
	rem_t [1:0]             rem_n;
	axis_t                  major_n;
	mode_t                  mode_n;
	logic [IVAL_W-1:0]      ival_n;
	logic [NUM_AXES-1:0]    step_n;

	logic                   adv;
	logic                   period_due;
	logic [IVAL_W-1:0]      ival_reload;
	mode_t                  home_mode;
	logic [NUM_AXES-1:0]    home_sel;
	logic [NUM_AXES-1:0]    home_step;
	logic                   home_done;
	logic                   home_apply;

	tasi_plan_t             plan;
	tasi_period_t           per;

	tasi_planner u_planner (
		.target (tgt_s1),
		.pos    (pos_q),
		.plan   (plan)
	);

	tasi_stepper u_stepper (
		.span  (dist_q),
		.cnt   (cnt_q),
		.rem   (rem_q),
		.major (major_q),
		.per   (per)
	);

	// Handshake: advance when the result register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

	// Period timing and homing selection
	assign period_due  = (ival_q == '0);
	assign ival_reload = (ival_cfg_q == '0) ? '0 : (ival_cfg_q - 1'b1);
	assign home_mode   = (mode_q == MODE_IDLE) ?
		((op_s1 == OP_HOME_X) ? MODE_HOME_X : MODE_HOME_ALL) : mode_q;
	assign home_sel    = (home_mode == MODE_HOME_X) ? 3'b001 : 3'b111;
	assign home_step   = home_sel & lim_s1;
	assign home_done   = (home_step == '0);

	// Next mode
	always_comb begin
		mode_n = mode_q;
		case (mode_q)
			MODE_IDLE: begin
				case (op_s1)
					OP_MOVE:     mode_n = plan.active ? MODE_MOVE : MODE_IDLE;
					OP_HOME_ALL: mode_n = home_done ? MODE_IDLE : MODE_HOME_ALL;
					OP_HOME_X:   mode_n = home_done ? MODE_IDLE : MODE_HOME_X;
					default:     mode_n = MODE_IDLE;
				endcase
			end
			MODE_MOVE: begin
				if (period_due && per.done) mode_n = MODE_IDLE;
			end
			MODE_HOME_ALL, MODE_HOME_X: begin
				if (period_due && home_done) mode_n = MODE_IDLE;
			end
			default: mode_n = MODE_IDLE;
		endcase
	end

	// Datapath: commands, step periods and position update
	always_comb begin
		dir_n      = dir_q;
		dist_n     = dist_q;
		cnt_n      = cnt_q;
		rem_n      = rem_q;
		major_n    = major_q;
		ival_n     = ival_q;
		step_n     = '0;
		home_apply = 1'b0;

		case (mode_q)
			MODE_IDLE: begin
				case (op_s1)
					OP_MOVE: begin
						dir_n   = plan.dir;
						dist_n  = plan.span;
						major_n = plan.major;
						cnt_n   = plan.cnt;
						rem_n   = plan.rem;
						step_n  = plan.step;
						ival_n  = plan.active ? ival_reload : '0;
					end
					OP_HOME_ALL, OP_HOME_X: home_apply = 1'b1;
					default: ival_n = ival_q;
				endcase
			end
			MODE_MOVE: begin
				if (period_due) begin
					if (!per.done) begin
						step_n = per.step;
						cnt_n  = per.cnt;
						rem_n  = per.rem;
						ival_n = ival_reload;
					end else begin
						ival_n = '0;
					end
				end else begin
					ival_n = ival_q - 1'b1;
				end
			end
			MODE_HOME_ALL, MODE_HOME_X: begin
				if (period_due) begin
					home_apply = 1'b1;
				end else begin
					ival_n = ival_q - 1'b1;
				end
			end
			default: ival_n = '0;
		endcase

		// Homing steps negative; when all switches close, homed axes go to zero
		if (home_apply) begin
			step_n = home_step;
			ival_n = home_done ? '0 : ival_reload;
			for (int a = 0; a < NUM_AXES; a++) begin
				if (home_sel[a]) dir_n[a] = home_done;
			end
		end

		for (int a = 0; a < NUM_AXES; a++) begin
			if (home_apply && home_done && home_sel[a]) begin
				pos_n[a] = '0;
			end else if (step_n[a]) begin
				pos_n[a] = dir_n[a] ? (pos_q[a] + 1'b1) : (pos_q[a] - 1'b1);
			end else begin
				pos_n[a] = pos_q[a];
			end
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1  <= op_t'(s_axis_tuser);
			tgt_s1 <= s_axis_tdata[NUM_AXES*COORD_W-1:0];
			lim_s1 <= s_axis_tdata[NUM_AXES*COORD_W +: NUM_AXES];
		end
	end

	// Step interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_cfg_q <= IVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ival_cfg_q <= cfg_data;
		end
	end

	// Axis and sequencing state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			dir_q   <= '1;
			dist_q  <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			major_q <= AXIS_X;
			mode_q  <= MODE_IDLE;
			ival_q  <= '0;
		end else if (adv) begin
			pos_q   <= pos_n;
			dir_q   <= dir_n;
			dist_q  <= dist_n;
			cnt_q   <= cnt_n;
			rem_q   <= rem_n;
			major_q <= major_n;
			mode_q  <= mode_n;
			ival_q  <= ival_n;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {
				{(OUT_DATA_W - 7 - 3 * COORD_W){1'b0}},
				COORD_W'(pos_n[2]), COORD_W'(pos_n[1]), COORD_W'(pos_n[0]),
				(mode_n != MODE_IDLE), dir_n, step_n
			};
		end
	end

endmodule

[rtl/tasi_planner.sv]
// Move planner: distances, directions, major axis and the first step period.
module tasi_planner (
	input  tasi_pkg::coord_t [tasi_pkg::NUM_AXES-1:0] target,
	input  tasi_pkg::pos_t [tasi_pkg::NUM_AXES-1:0]   pos,
	output tasi_pkg::tasi_plan_t                      plan
);
	import tasi_pkg::*;

	pos_t [NUM_AXES-1:0]  tw;
	dist_t [NUM_AXES-1:0] diff;
	dist_t [NUM_AXES-1:0] mag;
	axis_t                major;
	axis_t                mn;
	dist_t                dm;

	always_comb begin
		// Signed distance per axis, then magnitude and direction
		for (int a = 0; a < NUM_AXES; a++) begin
			tw[a]   = POS_W'($signed(target[a]));
			diff[a] = {tw[a][POS_W-1], tw[a]} - {pos[a][POS_W-1], pos[a]};
			mag[a]  = diff[a][DIST_W-1] ? (DIST_W'(0) - diff[a]) : diff[a];
		end

		// Pick the major axis: X wins ties, then Z over Y
		if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
			major = AXIS_X;
		end else if (mag[2] >= mag[0] && mag[2] >= mag[1]) begin
			major = AXIS_Z;
		end else begin
			major = AXIS_Y;
		end
		dm = mag[major];
		mn = AXIS_X;

		plan.major  = major;
		plan.span   = mag;
		plan.active = (dm != '0);
		plan.step   = '0;
		plan.cnt    = '0;
		plan.rem    = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			plan.dir[a] = ~diff[a][DIST_W-1];
		end

		// First period from zero counts: a minor steps only if it ties the major
		plan.step[major] = plan.active;
		plan.cnt[major]  = DIST_W'(plan.active);
		for (int k = 0; k < 2; k++) begin
			mn = minor_axis(major, 1'(k));
			if (plan.active) begin
				if (mag[mn] == dm) begin
					plan.step[mn] = 1'b1;
					plan.cnt[mn]  = DIST_W'(1);
				end else begin
					plan.rem[k] = REM_W'(mag[mn]);
				end
			end
		end
	end

endmodule

[rtl/tasi_stepper.sv]
// One step period of a running move: major step and minor remainder tests.
module tasi_stepper (
	input  tasi_pkg::dist_t [tasi_pkg::NUM_AXES-1:0] span,
	input  tasi_pkg::dist_t [tasi_pkg::NUM_AXES-1:0] cnt,
	input  tasi_pkg::rem_t [1:0]                     rem,
	input  tasi_pkg::axis_t                          major,
	output tasi_pkg::tasi_period_t                   per
);
	import tasi_pkg::*;

	rem_t  sum;
	axis_t mn;
	dist_t dm;

	always_comb begin
		dm       = span[major];
		sum      = '0;
		mn       = AXIS_X;
		per.done = (cnt[major] >= dm);
		per.step = '0;
		per.cnt  = cnt;
		per.rem  = rem;

		// Advance the major axis, then test each minor axis remainder
		if (!per.done) begin
			per.cnt[major]  = cnt[major] + 1'b1;
			per.step[major] = 1'b1;
			for (int k = 0; k < 2; k++) begin
				mn  = minor_axis(major, 1'(k));
				sum = rem[k] + REM_W'(span[mn]);
				if (sum >= REM_W'(dm)) begin
					per.rem[k]  = sum - REM_W'(dm);
					per.cnt[mn] = cnt[mn] + 1'b1;
					per.step[mn] = 1'b1;
				end else begin
					per.rem[k] = sum;
				end
			end
		end
	end

endmodule
